// ----- rtl/core/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared sizes, row types and outcome codes of the two-level cache lookup.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int ADDR_W      = 32;
  localparam int FIRST_SETS  = 64;
  localparam int FIRST_WAYS  = 4;
  localparam int SECOND_SETS = FIRST_SETS * 2;
  localparam int SECOND_WAYS = FIRST_WAYS * 2;

  localparam int L1_IDX_W = $clog2(FIRST_SETS);
  localparam int L2_IDX_W = $clog2(SECOND_SETS);
  localparam int L1_TAG_W = ADDR_W - L1_IDX_W;
  localparam int L2_TAG_W = ADDR_W - L2_IDX_W;
  localparam int L1_AGE_W = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
  localparam int L2_AGE_W = $clog2(SECOND_WAYS);

  localparam int OUT_W      = ADDR_W + 2;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [1:0] OUT_L1_HIT = 2'd0;
  localparam logic [1:0] OUT_L2_HIT = 2'd1;
  localparam logic [1:0] OUT_MISS   = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [L1_TAG_W-1:0] tag;
    logic [L1_AGE_W-1:0] age;
  } l1_way_t;

  typedef struct packed {
    logic                valid;
    logic [L2_TAG_W-1:0] tag;
    logic [L2_AGE_W-1:0] age;
  } l2_way_t;

  typedef l1_way_t [FIRST_WAYS-1:0]  l1_row_t;
  typedef l2_way_t [SECOND_WAYS-1:0] l2_row_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       l2_we;
  } tlc_result_t;

endpackage

// ----- rtl/core/tlc_update.sv -----
// ----------------------------------------------------------------------------
// tlc_update
// Tag compare, victim choice and LRU rank update for one L1 set and one
// L2 set read from the tag stores.
// ----------------------------------------------------------------------------
module tlc_update
  import tlc_pkg::*;
(
  input  l1_row_t             l1_row,
  input  l2_row_t             l2_row,
  input  logic [L1_TAG_W-1:0] l1_tag,
  input  logic [L2_TAG_W-1:0] l2_tag,
  output l1_row_t             l1_new,
  output l2_row_t             l2_new,
  output tlc_result_t         result
);

  localparam int L1_WAY_W = L1_AGE_W;
  localparam int L2_WAY_W = L2_AGE_W;

  logic                l1_hit;
  logic [L1_WAY_W-1:0] l1_hw;
  logic                l1_inv;
  logic [L1_WAY_W-1:0] l1_vic;
  logic [L1_WAY_W-1:0] l1_tgt;
  logic [L1_AGE_W:0]   l1_old;

  logic                l2_hit;
  logic                l2_inv;
  logic [L2_WAY_W-1:0] l2_vic;
  logic [L2_AGE_W:0]   l2_old;

  always_comb begin
    l1_hit = 1'b0;
    l1_hw  = '0;
    l1_inv = 1'b0;
    l1_vic = '0;
    for (int i = FIRST_WAYS - 1; i >= 0; i--) begin
      if (l1_row[i].valid && l1_row[i].tag == l1_tag) begin
        l1_hit = 1'b1;
        l1_hw  = L1_WAY_W'(i);
      end
      if (!l1_row[i].valid) begin
        l1_inv = 1'b1;
        l1_vic = L1_WAY_W'(i);
      end
    end
    if (!l1_inv) begin
      l1_vic = '0;
      for (int i = 1; i < FIRST_WAYS; i++) begin
        if (l1_row[i].age > l1_row[l1_vic].age) begin
          l1_vic = L1_WAY_W'(i);
        end
      end
    end
    l1_tgt = l1_hit ? l1_hw : l1_vic;
    l1_old = l1_row[l1_tgt].valid ? {1'b0, l1_row[l1_tgt].age}
                                  : (L1_AGE_W + 1)'(FIRST_WAYS);
    l1_new = l1_row;
    for (int i = 0; i < FIRST_WAYS; i++) begin
      if (L1_WAY_W'(i) != l1_tgt && l1_row[i].valid && {1'b0, l1_row[i].age} < l1_old) begin
        l1_new[i].age = l1_row[i].age + 1'b1;
      end
    end
    l1_new[l1_tgt].valid = 1'b1;
    l1_new[l1_tgt].tag   = l1_tag;
    l1_new[l1_tgt].age   = '0;
  end

  always_comb begin
    l2_hit = 1'b0;
    l2_inv = 1'b0;
    l2_vic = '0;
    for (int i = SECOND_WAYS - 1; i >= 0; i--) begin
      if (l2_row[i].valid && l2_row[i].tag == l2_tag) begin
        l2_hit = 1'b1;
      end
      if (!l2_row[i].valid) begin
        l2_inv = 1'b1;
        l2_vic = L2_WAY_W'(i);
      end
    end
    if (!l2_inv) begin
      l2_vic = '0;
      for (int i = 1; i < SECOND_WAYS; i++) begin
        if (l2_row[i].age > l2_row[l2_vic].age) begin
          l2_vic = L2_WAY_W'(i);
        end
      end
    end
    l2_old = l2_row[l2_vic].valid ? {1'b0, l2_row[l2_vic].age}
                                  : (L2_AGE_W + 1)'(SECOND_WAYS);
    l2_new = l2_row;
    for (int i = 0; i < SECOND_WAYS; i++) begin
      if (L2_WAY_W'(i) != l2_vic && l2_row[i].valid && {1'b0, l2_row[i].age} < l2_old) begin
        l2_new[i].age = l2_row[i].age + 1'b1;
      end
    end
    l2_new[l2_vic].valid = 1'b1;
    l2_new[l2_vic].tag   = l2_tag;
    l2_new[l2_vic].age   = '0;
  end

  always_comb begin
    if (l1_hit) begin
      result.outcome = OUT_L1_HIT;
    end else if (l2_hit) begin
      result.outcome = OUT_L2_HIT;
    end else begin
      result.outcome = OUT_MISS;
    end
    result.l2_we = !l1_hit && !l2_hit;
  end

endmodule

// ----- rtl/core/two_level_lru_cache_lookup_core.sv -----
// Flow: on accept the L1 and L2 sets are read into registers; the update
// state then writes the tag stores back and registers the result beat. The
// next read waits for that write-back, and a stalled output holds the update.
// Reset: synchronous; clears per-row valid flags of both tag stores at once,
// so every set reads as empty right after reset. No clearing pass is needed.
// ----------------------------------------------------------------------------
// two_level_lru_cache_lookup_core
// Block address lookup in an L1 and an L2 set-associative tag store with
// LRU ranks, read-modify-write over single-port synchronous memories.
// ----------------------------------------------------------------------------
module two_level_lru_cache_lookup_core
  import tlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] block_address
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] address_echo, [33:32] outcome
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state, state_next;

  l1_row_t l1_mem [FIRST_SETS];
  l2_row_t l2_mem [SECOND_SETS];
  logic [FIRST_SETS-1:0]  l1_row_valid;
  logic [SECOND_SETS-1:0] l2_row_valid;

  l1_row_t l1_rd;
  l2_row_t l2_rd;
  logic    l1_rd_valid;
  logic    l2_rd_valid;
  logic [ADDR_W-1:0] addr;

  l1_row_t     l1_cur, l1_new;
  l2_row_t     l2_cur, l2_new;
  tlc_result_t result;

  logic accept;
  logic update_go;
  logic m_tvalid_next;

  logic [L1_IDX_W-1:0] s_l1_idx, l1_idx;
  logic [L2_IDX_W-1:0] s_l2_idx, l2_idx;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign update_go = (state == ST_UPDATE) && (!m_tvalid || m_tready);

  assign s_l1_idx = s_tdata[L1_IDX_W-1:0];
  assign s_l2_idx = s_tdata[L2_IDX_W-1:0];
  assign l1_idx   = addr[L1_IDX_W-1:0];
  assign l2_idx   = addr[L2_IDX_W-1:0];

  assign l1_cur = l1_rd_valid ? l1_rd : '0;
  assign l2_cur = l2_rd_valid ? l2_rd : '0;

  tlc_update u_update (
    .l1_row (l1_cur),
    .l2_row (l2_cur),
    .l1_tag (addr[ADDR_W-1:L1_IDX_W]),
    .l2_tag (addr[ADDR_W-1:L2_IDX_W]),
    .l1_new (l1_new),
    .l2_new (l2_new),
    .result (result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (update_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (update_go) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      l1_row_valid <= '0;
      l2_row_valid <= '0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
      if (update_go) begin
        l1_row_valid[l1_idx] <= 1'b1;
        if (result.l2_we) begin
          l2_row_valid[l2_idx] <= 1'b1;
        end
      end
    end
  end

  // tag stores: read on accept, write back on update (L2 only on a double miss)
  always_ff @(posedge clk) begin
    if (accept) begin
      l1_rd       <= l1_mem[s_l1_idx];
      l2_rd       <= l2_mem[s_l2_idx];
      l1_rd_valid <= l1_row_valid[s_l1_idx];
      l2_rd_valid <= l2_row_valid[s_l2_idx];
      addr        <= s_tdata;
    end
    if (update_go) begin
      l1_mem[l1_idx] <= l1_new;
      if (result.l2_we) begin
        l2_mem[l2_idx] <= l2_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      m_tdata <= OUT_DATA_W'({result.outcome, addr});
    end
  end

`ifndef ASSERT_OFF
  a_no_bad_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ADDR_W+1:ADDR_W] != 2'b11))
    else $error("outcome code 3 on output");

  a_l2_write_on_miss: assert property (@(posedge clk) disable iff (rst)
    (update_go && result.l2_we) |=> (m_tdata[ADDR_W+1:ADDR_W] == OUT_MISS))
    else $error("L2 fill without double miss");

  a_no_accept_in_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while update pending");

  a_update_gives_beat: assert property (@(posedge clk) disable iff (rst)
    update_go |=> (m_tvalid && m_tdata[ADDR_W-1:0] == $past(addr)))
    else $error("update did not produce result beat");
`endif

endmodule
